/* design/pid_sc_pkg.sv */
package pid_sc_pkg;

    // Fixed-point format of speeds and gains
    localparam int FRAC_BITS = 8;
    localparam int SHIFT     = 2 * FRAC_BITS;

    // Field widths
    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 16;
    localparam int DUTY_W  = 16;
    localparam int MAXD_W  = 15;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int SUM_W   = 32;

    // Product and accumulator widths
    localparam int PP_W   = GAIN_W + ERR_W;
    localparam int PI_W   = GAIN_W + SUM_W;
    localparam int PD_W   = GAIN_W + DIFF_W;
    localparam int ACC_W  = PI_W + 2;
    localparam int QUOT_W = ACC_W - SHIFT;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 3'd3;

    localparam logic [MAXD_W-1:0] MAX_DUTY_RST = 15'd1000;

    typedef logic signed [SPEED_W-1:0] t_speed;
    typedef logic signed [GAIN_W-1:0]  t_gain;
    typedef logic signed [DUTY_W-1:0]  t_duty;

endpackage

/* design/pid_speed_controller.sv */
// PID wheel-speed controller. Each input transaction carries a target and a
// measured speed (signed Q8.8) and yields exactly one output transaction, a
// signed duty command. The error (target - measured) feeds a saturating 32-bit
// integrator and a first difference against the previous error; the three
// terms are weighted by Q8.8 gains, summed exactly, truncated toward zero to
// an integer, saturated to 16 bits and then clamped to [0, max_duty] for a
// positive target or to [-max_duty, 0] otherwise. A transaction passes through
// the input register, the error/integrator stage, the multiplier stage, the
// accumulate stage and the clamp/output register. One transaction is accepted
// every cycle while o_in_stall is low; the integrator and previous-error
// registers update as each tick leaves the input register, so back-to-back
// ticks are handled at full rate. Each stage holds its contents only while the
// stage after it is full and stalled, so a waiting result does not block new
// input while bubbles remain. The user must write gains and max_duty through
// the configuration port only while the pipeline is empty; the block does not
// enforce this. Index 0 prop_gain, 1 integ_gain, 2 deriv_gain, 3 max_duty (15
// bits), other indexes are ignored. Reset clears the integrator and previous
// error, zeroes the gains and sets max_duty to 1000.
module pid_speed_controller
    import pid_sc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SPEED_W-1:0]    i_target_speed,
    input  logic [SPEED_W-1:0]    i_measured_speed,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DUTY_W-1:0]     o_duty
);

    // Configuration registers
    t_gain               r_prop_gain;
    t_gain               r_integ_gain;
    t_gain               r_deriv_gain;
    logic [MAXD_W-1:0]   r_max_duty;

    // Controller state
    logic signed [SUM_W-1:0] r_error_sum;
    logic signed [ERR_W-1:0] r_last_error;

    // Stage valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // Stage 1: input register
    t_speed r_target1, r_measured1;
    // Stage 2: error, difference, integrator
    logic signed [ERR_W-1:0]  r_err2;
    logic signed [DIFF_W-1:0] r_diff2;
    logic signed [SUM_W-1:0]  r_sum2;
    logic                     r_pos2;
    // Stage 3: products
    logic signed [PP_W-1:0]   r_pp3;
    logic signed [PI_W-1:0]   r_pi3;
    logic signed [PD_W-1:0]   r_pd3;
    logic                     r_pos3;
    // Stage 4: exact sum
    logic signed [ACC_W-1:0]  r_acc4;
    logic                     r_pos4;
    // Stage 5: output register
    t_duty                    r_duty5;

    // Handshake: each stage loads when empty or when its content moves on
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic mv1, mv2, mv3, mv4;
    logic in_accept;

    assign rdy5 = !r_v5 || !i_out_stall;
    assign mv4  = r_v4 && rdy5;
    assign rdy4 = !r_v4 || mv4;
    assign mv3  = r_v3 && rdy4;
    assign rdy3 = !r_v3 || mv3;
    assign mv2  = r_v2 && rdy3;
    assign rdy2 = !r_v2 || mv2;
    assign mv1  = r_v1 && rdy2;
    assign rdy1 = !r_v1 || mv1;

    assign o_in_stall  = !rdy1;
    assign in_accept   = i_in_valid && rdy1;
    assign o_out_valid = r_v5;
    assign o_duty      = r_duty5;

    // Stage 2 logic: error, first difference, saturating integrator
    logic signed [ERR_W-1:0]  n_err;
    logic signed [DIFF_W-1:0] n_diff;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     n_pos;

    always_comb begin
        n_err    = {r_target1[SPEED_W-1], r_target1} - {r_measured1[SPEED_W-1], r_measured1};
        n_diff   = {n_err[ERR_W-1], n_err} - {r_last_error[ERR_W-1], r_last_error};
        sum_wide = {r_error_sum[SUM_W-1], r_error_sum}
                 + {{(SUM_W + 1 - ERR_W){n_err[ERR_W-1]}}, n_err};
        // Clip to the signed 32-bit range on overflow
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            n_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_sum = sum_wide[SUM_W-1:0];
        end
        n_pos = !r_target1[SPEED_W-1] && (|r_target1);
    end

    // Stage 3 logic: one multiplier per term
    logic signed [PP_W-1:0] n_pp;
    logic signed [PI_W-1:0] n_pi;
    logic signed [PD_W-1:0] n_pd;

    always_comb begin
        n_pp = PP_W'(r_prop_gain) * PP_W'(r_err2);
        n_pi = PI_W'(r_integ_gain) * PI_W'(r_sum2);
        n_pd = PD_W'(r_deriv_gain) * PD_W'(r_diff2);
    end

    // Stage 4 logic: exact sum of the three terms
    logic signed [ACC_W-1:0] n_acc;

    always_comb begin
        n_acc = {{(ACC_W - PP_W){r_pp3[PP_W-1]}}, r_pp3}
              + {{(ACC_W - PI_W){r_pi3[PI_W-1]}}, r_pi3}
              + {{(ACC_W - PD_W){r_pd3[PD_W-1]}}, r_pd3};
    end

    // Stage 5 logic: truncate toward zero, saturate, direction clamp
    logic signed [ACC_W-1:0]  biased;
    logic signed [QUOT_W-1:0] quot;
    t_duty                    sat;
    t_duty                    lim;
    t_duty                    n_duty;

    always_comb begin
        // Bias negative values so the floor shift rounds toward zero
        biased = r_acc4 + (r_acc4[ACC_W-1] ? {{(ACC_W - SHIFT){1'b0}}, {SHIFT{1'b1}}}
                                           : {ACC_W{1'b0}});
        quot   = biased[ACC_W-1:SHIFT];
        if (quot > QUOT_W'(signed'(32'sd32767))) begin
            sat = 16'sh7FFF;
        end else if (quot < QUOT_W'(signed'(-32'sd32768))) begin
            sat = 16'sh8000;
        end else begin
            sat = quot[DUTY_W-1:0];
        end
        lim = {1'b0, r_max_duty};
        if (r_pos4) begin
            if (sat < 16'sd0) begin
                n_duty = '0;
            end else if (sat > lim) begin
                n_duty = lim;
            end else begin
                n_duty = sat;
            end
        end else begin
            if (sat > 16'sd0) begin
                n_duty = '0;
            end else if (sat < -lim) begin
                n_duty = -lim;
            end else begin
                n_duty = sat;
            end
        end
    end

    // Control state: valid bits, controller state, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_v5         <= 1'b0;
            r_error_sum  <= '0;
            r_last_error <= '0;
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_max_duty   <= MAX_DUTY_RST;
        end else begin
            if (rdy1) r_v1 <= in_accept;
            if (rdy2) r_v2 <= mv1;
            if (rdy3) r_v3 <= mv2;
            if (rdy4) r_v4 <= mv3;
            if (rdy5) r_v5 <= mv4;

            // Advance the integrator and previous error as each tick leaves stage 1
            if (mv1) begin
                r_error_sum  <= n_sum;
                r_last_error <= n_err;
            end

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_PROP_GAIN:  r_prop_gain  <= i_cfg_wdata[GAIN_W-1:0];
                    REG_INTEG_GAIN: r_integ_gain <= i_cfg_wdata[GAIN_W-1:0];
                    REG_DERIV_GAIN: r_deriv_gain <= i_cfg_wdata[GAIN_W-1:0];
                    REG_MAX_DUTY:   r_max_duty   <= i_cfg_wdata[MAXD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_target1   <= i_target_speed;
            r_measured1 <= i_measured_speed;
        end
        if (mv1) begin
            r_err2  <= n_err;
            r_diff2 <= n_diff;
            r_sum2  <= n_sum;
            r_pos2  <= n_pos;
        end
        if (mv2) begin
            r_pp3  <= n_pp;
            r_pi3  <= n_pi;
            r_pd3  <= n_pd;
            r_pos3 <= r_pos2;
        end
        if (mv3) begin
            r_acc4 <= n_acc;
            r_pos4 <= r_pos3;
        end
        if (mv4) begin
            r_duty5 <= n_duty;
        end
    end

endmodule
